[sv/assert_macros.svh]
// Assertion macros shared by the framer RTL.
// Standalone header; no other file is needed to use it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define MBMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define MBMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/mbmf_pkg.sv]
// Package for the MIDI byte message framer: parse state, byte codes, flag types.
// No dependencies.
`timescale 1ns / 1ps

package mbmf_pkg;

    // Byte code boundaries and system codes
    localparam logic [7:0] DATA_LAST        = 8'h7F;
    localparam logic [7:0] STATUS_FIRST     = 8'h80;
    localparam logic [7:0] ONE_PARAM_FIRST  = 8'hC0;
    localparam logic [7:0] ONE_PARAM_LAST   = 8'hDF;
    localparam logic [7:0] CHAN_LAST        = 8'hEF;
    localparam logic [7:0] SYSEX_START      = 8'hF0;
    localparam logic [7:0] MTC_QUARTER      = 8'hF1;
    localparam logic [7:0] SONG_POSITION    = 8'hF2;
    localparam logic [7:0] SONG_SELECT      = 8'hF3;
    localparam logic [7:0] SYSEX_END        = 8'hF7;
    localparam logic [7:0] SYS_COMMON_LAST  = 8'hF7;
    localparam logic [7:0] REALTIME_FIRST   = 8'hF8;
    localparam logic [7:0] BYTE_MAX         = 8'hFF;

    typedef enum logic [2:0] {
        ST_UNKNOWN    = 3'd0,
        ST_ONE        = 3'd1,
        ST_ONE_CONT   = 3'd2,
        ST_TWO_FIRST  = 3'd3,
        ST_TWO_SECOND = 3'd4,
        ST_TWO_CONT   = 3'd5,
        ST_SYSEX      = 3'd6
    } t_parse_state;

    typedef struct packed {
        logic starts_message;
        logic running_status_repeat;
    } t_flags;

    typedef struct packed {
        logic [7:0] echoed_byte;
        t_flags     flags;
    } t_result;

endpackage

[sv/mbmf_byte_if.sv]
// Input channel interface: one raw MIDI byte per word.
// No dependencies.
`timescale 1ns / 1ps

interface mbmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

[sv/mbmf_msg_if.sv]
// Output channel interface: echoed byte plus framing flags per word.
// No dependencies.
`timescale 1ns / 1ps

interface mbmf_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] echoed_byte;
    logic       starts_message;
    logic       running_status_repeat;

    modport source (output valid, output echoed_byte, output starts_message,
                    output running_status_repeat, input ready);
    modport sink   (input valid, input echoed_byte, input starts_message,
                    input running_status_repeat, output ready);
endinterface

[sv/mbmf_decode.sv]
// Combinational byte decoder: next parse state and framing flags.
// Depends on mbmf_pkg.
`timescale 1ns / 1ps

module mbmf_decode
    import mbmf_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    output t_parse_state o_next_state,
    output t_flags       o_flags
);

    t_parse_state st_eff;

    // Fold the unused code into unknown
    always_comb begin
        case (i_state) inside
            ST_ONE, ST_ONE_CONT, ST_TWO_FIRST, ST_TWO_SECOND, ST_TWO_CONT,
            ST_SYSEX: begin
                st_eff = i_state;
            end
            default: begin
                st_eff = ST_UNKNOWN;
            end
        endcase
    end

    // Next state
    always_comb begin
        case (i_byte) inside
            [REALTIME_FIRST:BYTE_MAX]: o_next_state = st_eff;
            SYSEX_START:               o_next_state = ST_SYSEX;
            MTC_QUARTER, SONG_SELECT:  o_next_state = ST_ONE;
            SONG_POSITION:             o_next_state = ST_TWO_FIRST;
            [SYSEX_START:SYS_COMMON_LAST]: o_next_state = ST_UNKNOWN;
            [ONE_PARAM_FIRST:ONE_PARAM_LAST]: o_next_state = ST_ONE;
            [STATUS_FIRST:CHAN_LAST]:  o_next_state = ST_TWO_FIRST;
            default: begin
                case (st_eff)
                    ST_ONE:        o_next_state = ST_ONE_CONT;
                    ST_TWO_FIRST:  o_next_state = ST_TWO_SECOND;
                    ST_TWO_SECOND: o_next_state = ST_TWO_CONT;
                    ST_TWO_CONT:   o_next_state = ST_TWO_SECOND;
                    default:       o_next_state = st_eff;
                endcase
            end
        endcase
    end

    // Flags
    always_comb begin
        o_flags = '0;
        case (i_byte) inside
            SYSEX_END: begin
                o_flags.starts_message = (st_eff != ST_SYSEX);
            end
            [STATUS_FIRST:BYTE_MAX]: begin
                o_flags.starts_message = 1'b1;
            end
            default: begin
                o_flags.starts_message        = (st_eff == ST_UNKNOWN);
                o_flags.running_status_repeat = (st_eff == ST_ONE_CONT) ||
                                                (st_eff == ST_TWO_CONT);
            end
        endcase
    end

endmodule

[sv/mbmf_result_reg.sv]
// Result register stage with valid/ready toward the output channel.
// Depends on mbmf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbmf_result_reg
    import mbmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    input  logic    i_out_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    // Free when empty or when the held word leaves this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `MBMF_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !r_valid, "valid after reset")
    `MBMF_ASSERT(a_load_sets, i_clk, i_rst_n, i_load |=> r_valid, "load lost")
    `MBMF_ASSERT(a_load_data, i_clk, i_rst_n, i_load |=> (r_data == $past(i_data)), "data not captured")
    `MBMF_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_valid && !i_out_ready) |-> !o_can_load, "overwrite of held word")

endmodule

[sv/midi_byte_message_framer_core.sv]
// Top level of the MIDI byte message framer: parse state register,
// decoder and result register. Depends on mbmf_pkg, both channel
// interfaces, mbmf_decode and mbmf_result_reg.
`timescale 1ns / 1ps

//  channel | dir | word payload                                        | handshake
//  i_in    | in  | midi_byte[7:0]                                      | valid/ready
//  o_out   | out | echoed_byte[7:0], starts_message, running_status_rep | valid/ready
//
//  One word per cycle sustained while o_out takes words; a byte shows at o_out
//  in the cycle after it is taken. The rate is set by the single parse state
//  register, which the decoder reads and rewrites in the same cycle a byte is taken.
//  Synchronous active-low reset returns the parser to unknown and empties
//  the result register. A stalled o_out holds its word; i_in.ready drops
//  only while a held result is not being taken.

module midi_byte_message_framer_core
    import mbmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbmf_byte_if.sink   i_in,
    mbmf_msg_if.source  o_out
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_flags       dec_flags;
    t_result      dec_result;
    t_result      out_result;
    logic         can_load;
    logic         in_accept;

    // Take a byte whenever the result register is free or draining
    assign i_in.ready = can_load;
    assign in_accept  = i_in.valid && can_load;

    // Decode the byte against the current parse state
    mbmf_decode u_decode (
        .i_state      (r_state),
        .i_byte       (i_in.midi_byte),
        .o_next_state (n_state),
        .o_flags      (dec_flags)
    );

    // Advance the parse state only on an accepted byte; hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_UNKNOWN;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Echo the byte with its flags
    assign dec_result.echoed_byte = i_in.midi_byte;
    assign dec_result.flags       = dec_flags;

    mbmf_result_reg u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_data      (dec_result),
        .i_out_ready (o_out.ready),
        .o_can_load  (can_load),
        .o_valid     (o_out.valid),
        .o_data      (out_result)
    );

    assign o_out.echoed_byte           = out_result.echoed_byte;
    assign o_out.starts_message        = out_result.flags.starts_message;
    assign o_out.running_status_repeat = out_result.flags.running_status_repeat;

endmodule

[bench/tb_midi_byte_message_framer_core.sv]
// Self-checking bench for midi_byte_message_framer_core: a directed byte table, then
// random well-formed MIDI traffic with noise, under random bursts and output stalls.
// Depends on midi_byte_message_framer_core, mbmf_pkg, mbmf_byte_if and mbmf_msg_if.
`timescale 1ns / 1ps

module tb_midi_byte_message_framer_core
    import mbmf_pkg::*;
();

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_BYTES     = 1900;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_AFTER_WORDS = 500;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 4;
    localparam int REPORT_LIMIT     = 10;
    localparam int DIRECTED_ROWS    = 25;

    // System common codes that the package leaves unnamed
    localparam logic [7:0] SYS_UNDEFINED_1 = 8'hF4;
    localparam logic [7:0] SYS_UNDEFINED_2 = 8'hF5;
    localparam logic [7:0] TUNE_REQUEST    = 8'hF6;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       known;      // expected flags typed in below
        logic       start;
        logic       repeat_flag;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    mbmf_byte_if in_if ();
    mbmf_msg_if  out_if ();

    midi_byte_message_framer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_parse_state parser_state;
    t_result      expected_framing [$];
    logic [7:0]   random_bytes [$];

    int bytes_sent;
    int out_words;
    int starts_seen;
    int repeats_seen;
    int input_stall_cycles;
    int mismatches;
    int fail_count;
    int idle_cycles;
    bit run_done;

    // Known rows: anything after reset, status bytes, real-time bytes.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{8'h00,          1'b1, 1'b1, 1'b0},  // stray data after reset
        '{BYTE_MAX,       1'b1, 1'b1, 1'b0},  // real-time, state held
        '{STATUS_FIRST,   1'b1, 1'b1, 1'b0},  // note off, two parameters
        '{8'h3C,          1'b0, 1'b0, 1'b0},
        '{8'h40,          1'b0, 1'b0, 1'b0},
        '{REALTIME_FIRST, 1'b1, 1'b1, 1'b0},  // real-time inside running status
        '{8'h3E,          1'b0, 1'b0, 1'b0},  // running-status repeat
        '{8'h7F,          1'b0, 1'b0, 1'b0},
        '{CHAN_LAST,      1'b1, 1'b1, 1'b0},
        '{8'h01,          1'b0, 1'b0, 1'b0},
        '{ONE_PARAM_FIRST,1'b1, 1'b1, 1'b0},
        '{8'h05,          1'b0, 1'b0, 1'b0},
        '{8'h06,          1'b0, 1'b0, 1'b0},  // one-parameter repeat
        '{ONE_PARAM_LAST, 1'b1, 1'b1, 1'b0},
        '{SYSEX_START,    1'b1, 1'b1, 1'b0},
        '{8'h12,          1'b0, 1'b0, 1'b0},
        '{SYSEX_END,      1'b0, 1'b0, 1'b0},  // closes the exclusive
        '{SYSEX_END,      1'b0, 1'b0, 1'b0},  // stray end of exclusive
        '{MTC_QUARTER,    1'b1, 1'b1, 1'b0},
        '{8'h7F,          1'b0, 1'b0, 1'b0},
        '{SONG_POSITION,  1'b1, 1'b1, 1'b0},
        '{8'h02,          1'b0, 1'b0, 1'b0},
        '{SONG_SELECT,    1'b1, 1'b1, 1'b0},
        '{SYS_UNDEFINED_1,1'b1, 1'b1, 1'b0},
        '{TUNE_REQUEST,   1'b1, 1'b1, 1'b0}
    };

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Advance the parser copy by one byte and return the word it should produce.
    function automatic t_result frame_midi_byte(input logic [7:0] b);
        t_result      r;
        t_parse_state nxt;
        nxt = parser_state;
        r.echoed_byte                 = b;
        r.flags.starts_message        = 1'b0;
        r.flags.running_status_repeat = 1'b0;
        if (b >= REALTIME_FIRST) begin
            r.flags.starts_message = 1'b1;
        end else if (b >= SYSEX_START) begin
            r.flags.starts_message = 1'b1;
            case (b)
                SYSEX_START:               nxt = ST_SYSEX;
                MTC_QUARTER, SONG_SELECT:  nxt = ST_ONE;
                SONG_POSITION:             nxt = ST_TWO_FIRST;
                SYSEX_END: begin
                    r.flags.starts_message = (parser_state != ST_SYSEX);
                    nxt = ST_UNKNOWN;
                end
                default:                   nxt = ST_UNKNOWN;
            endcase
        end else if (b >= STATUS_FIRST) begin
            r.flags.starts_message = 1'b1;
            nxt = (b >= ONE_PARAM_FIRST && b <= ONE_PARAM_LAST) ? ST_ONE : ST_TWO_FIRST;
        end else begin
            r.flags.starts_message = (parser_state == ST_UNKNOWN);
            case (parser_state)
                ST_ONE:        nxt = ST_ONE_CONT;
                ST_ONE_CONT:   r.flags.running_status_repeat = 1'b1;
                ST_TWO_FIRST:  nxt = ST_TWO_SECOND;
                ST_TWO_SECOND: nxt = ST_TWO_CONT;
                ST_TWO_CONT: begin
                    r.flags.running_status_repeat = 1'b1;
                    nxt = ST_TWO_SECOND;
                end
                default:       nxt = parser_state;
            endcase
        end
        parser_state = nxt;
        return r;
    endfunction

    // Offer one byte and hold it until taken; log the expected word on acceptance.
    task automatic send_word(input logic [7:0] b, input bit known,
                             input logic exp_start, input logic exp_repeat);
        t_result framed;
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.midi_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        framed = frame_midi_byte(b);
        if (known) begin
            framed.flags.starts_message        = exp_start;
            framed.flags.running_status_repeat = exp_repeat;
        end
        expected_framing.push_back(framed);
        bytes_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the byte lines.
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            in_if.valid     <= 1'b0;
            in_if.midi_byte <= 8'($urandom);
            repeat (cycles - 1) begin
                @(negedge i_clk);
                in_if.midi_byte <= 8'($urandom);
            end
        end
    endtask

    // Queue a byte, now and then preceded by an interleaved real-time byte.
    task automatic push_midi(input logic [7:0] b);
        if ($urandom_range(0, 19) == 0)
            random_bytes.push_back(8'($urandom_range(REALTIME_FIRST, BYTE_MAX)));
        random_bytes.push_back(b);
    endtask

    task automatic push_data(input int count);
        repeat (count) push_midi(8'($urandom_range(0, DATA_LAST)));
    endtask

    // Build mostly well-formed messages with running status, plus broken ones and noise.
    task automatic build_random_stream();
        logic [7:0] status;
        int         params;
        int         kind;
        while (random_bytes.size() < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                status = 8'($urandom_range(STATUS_FIRST, CHAN_LAST));
                params = (status >= ONE_PARAM_FIRST && status <= ONE_PARAM_LAST) ? 1 : 2;
                push_midi(status);
                repeat ($urandom_range(0, 4)) push_data(params);
                if ($urandom_range(0, 7) == 0)
                    push_data(1);  // one extra data byte; truncates a two-parameter message
            end else if (kind < 60) begin
                push_midi(SYSEX_START);
                push_data($urandom_range(0, 10));
                if ($urandom_range(0, 9) != 0)
                    push_midi(SYSEX_END);
            end else if (kind < 72) begin
                case ($urandom_range(0, 3))
                    0: begin
                        push_midi(MTC_QUARTER);
                        push_data($urandom_range(0, 3));
                    end
                    1: begin
                        push_midi(SONG_SELECT);
                        push_data($urandom_range(0, 3));
                    end
                    2: begin
                        push_midi(SONG_POSITION);
                        push_data($urandom_range(0, 5));
                    end
                    default: begin
                        push_midi(8'($urandom_range(SYS_UNDEFINED_1, TUNE_REQUEST)));
                        push_data($urandom_range(0, 2));
                    end
                endcase
            end else if (kind < 80) begin
                if ($urandom_range(0, 1) == 0)
                    push_midi(SYSEX_END);
                else
                    push_data($urandom_range(1, 3));
            end else begin
                repeat ($urandom_range(1, 4)) random_bytes.push_back(8'($urandom));
            end
        end
    endtask

    // Receiver: stall on rotating patterns, and once hold off long enough to back up the input.
    initial begin : receiver
        bit [15:0] stall_pattern;
        int        phase_cycles;
        bit        hold_done;
        out_if.ready  = 1'b0;
        stall_pattern = 16'hFFFF;
        phase_cycles  = 0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && out_words >= HOLD_AFTER_WORDS) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (phase_cycles == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_pattern = 16'hFFFF;
                        1:       stall_pattern = 16'($urandom) | 16'h0001;
                        2:       stall_pattern = 16'h0101;
                        default: stall_pattern = 16'h7FFF;
                    endcase
                    phase_cycles = $urandom_range(32, 160);
                end
                phase_cycles--;
                out_if.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // Check each taken word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            t_result want;
            out_words++;
            if (out_if.starts_message)        starts_seen++;
            if (out_if.running_status_repeat) repeats_seen++;
            if (expected_framing.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected word byte=%02h start=%0b repeat=%0b",
                             out_if.echoed_byte, out_if.starts_message,
                             out_if.running_status_repeat);
            end else begin
                want = expected_framing.pop_front();
                if (out_if.echoed_byte !== want.echoed_byte
                        || out_if.starts_message !== want.flags.starts_message
                        || out_if.running_status_repeat !== want.flags.running_status_repeat)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: word %0d exp %02h s=%0b r=%0b got %02h s=%0b r=%0b",
                                 out_words, want.echoed_byte, want.flags.starts_message,
                                 want.flags.running_status_repeat, out_if.echoed_byte,
                                 out_if.starts_message, out_if.running_status_repeat);
                end
            end
        end
    end

    // Count back-pressure and cycles with no progress on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && !in_if.ready)
            input_stall_cycles++;
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (!run_done && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_midi_byte_message_framer_core: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int idx;
        int burst;
        in_if.valid     = 1'b0;
        in_if.midi_byte = 8'h00;
        i_rst_n         = 1'b0;
        parser_state    = ST_UNKNOWN;
        run_done        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with short random gaps.
        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].midi_byte, directed_rows[r].known,
                      directed_rows[r].start, directed_rows[r].repeat_flag);
            idle_gap($urandom_range(0, 2));
        end

        // Random traffic in bursts; about a quarter of the gaps are empty.
        build_random_stream();
        idx = 0;
        while (idx < random_bytes.size()) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < random_bytes.size()) begin
                send_word(random_bytes[idx], 1'b0, 1'b0, 1'b0);
                idx++;
                burst--;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        idle_gap(1);

        // Drain, then let any stray word show up.
        wait (expected_framing.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        run_done = 1'b1;
        fail_count += expected_framing.size();

        $display("Run: %0d bytes sent (%0d directed), %0d checked, %0d starts, %0d repeats",
                 bytes_sent, DIRECTED_ROWS, out_words, starts_seen, repeats_seen);
        $display("Run: %0d input stall cycles, %0d mismatching words", input_stall_cycles,
                 mismatches);
        if (fail_count == 0) begin
            $display("tb_midi_byte_message_framer_core: PASS");
        end else begin
            $display("tb_midi_byte_message_framer_core: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/mbmf_pkg.sv
sv/mbmf_byte_if.sv
sv/mbmf_msg_if.sv
sv/mbmf_decode.sv
sv/mbmf_result_reg.sv
sv/midi_byte_message_framer_core.sv
bench/tb_midi_byte_message_framer_core.sv
